// ===== design/assert_macros.svh =====
// Assertion macros shared by the rendezvous table RTL.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on clk, skipped while rst_n is low
`define URT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("urt check failed");
// Check a property on clk, reset included
`define URT_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("urt check failed");
`else
`define URT_ASSERT(lbl, prop)
`define URT_ASSERT_ANY(lbl, prop)
`endif
`endif

// ===== design/urt_pkg.sv =====
// Types, constants and helper functions for the rendezvous pairing table.
// No dependencies; used by urt_front, urt_back and the top level.
package urt_pkg;

  // Input transaction as seen on the ports
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] now_ms;
    logic [63:0] nonce;
    logic [63:0] client_id;
    logic [63:0] session;
    logic [7:0]  player_id;
    logic [7:0]  code_length;
    logic [63:0] code_bytes;
    logic [31:0] source_address;
    logic [15:0] source_port;
  } in_item_t;

  // Result transaction as seen on the ports
  typedef struct packed {
    logic        kind;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic        slot;
    logic [63:0] slot_nonce;
    logic [63:0] session_out;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic        last;
  } out_item_t;

  localparam logic [1:0] FUNC_HELLO = 2'd0;
  localparam logic [1:0] FUNC_RELAY = 2'd1;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_FWD    = 1'b1;

  localparam logic [7:0]  LOOP_NET     = 8'd127;
  localparam int          XS_A         = 13;
  localparam int          XS_B         = 7;
  localparam int          XS_C         = 17;
  localparam logic [31:0] RST_TIMEOUT  = 32'd30000;
  localparam logic [31:0] RST_SALT     = 32'd1;
  localparam int          QDEPTH       = 2;
  localparam int          MAX_CODE     = 8;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_HELLO,
    OP_RELAY
  } op_t;

  typedef enum logic [1:0] {
    CFG_WAIT_TO,
    CFG_MATCH_TO,
    CFG_SALT,
    CFG_LOCAL
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] wait_to;
    logic [31:0] match_to;
    logic [31:0] salt;
    logic [31:0] local_addr;
  } cfg_t;

  // Classified work item handed from the front to the back
  typedef struct packed {
    op_t         op;
    logic [63:0] now;
    logic [63:0] nonce;
    logic [63:0] id;
    logic [63:0] session;
    logic        pid;
    logic [63:0] code;
    logic [3:0]  len;
    logic [47:0] src;
  } cmd_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] nonce;
    logic [63:0] id;
    logic [63:0] code;
    logic [3:0]  len;
    logic [47:0] src;
    logic [63:0] seen;
  } wait_rec_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] sess;
    logic [63:0] nonce0;
    logic [63:0] nonce1;
    logic [63:0] id0;
    logic [63:0] id1;
    logic [47:0] addr0;
    logic [47:0] addr1;
    logic [63:0] seen;
  } match_rec_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_ACT,
    BK_OUT0,
    BK_OUT1
  } bk_state_t;

  function automatic logic is_loop(input logic [31:0] a);
    return a[31:24] == LOOP_NET;
  endfunction

  // Xorshift mix of both nonces, time and salt; zero maps to one
  function automatic logic [63:0] new_session(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] now, input logic [31:0] salt);
    logic [63:0] v;
    v = a ^ (b << 1) ^ now ^ {salt, 32'd0};
    v = v ^ (v << XS_A);
    v = v ^ (v >> XS_B);
    v = v ^ (v << XS_C);
    return (v == 64'd0) ? 64'd1 : v;
  endfunction

  // Replace a loopback address by the local one when the peer is remote and the local one is set and not loopback
  function automatic logic [47:0] advertise(input logic [47:0] mine, input logic [47:0] other,
                                            input logic [31:0] la);
    if (is_loop(mine[47:16]) && !is_loop(other[47:16]) && la != 32'd0 && !is_loop(la))
      return {la, mine[15:0]};
    return mine;
  endfunction

endpackage

// ===== design/udp_pairing_rendezvous_table.sv =====
// Rendezvous pairing table. Each transaction (hello, relay or tick) takes one
// full pass over the waiting and match tables, which are read side by side
// under one scan counter. That pass searches both tables and ages every entry.
// A two-deep command queue sits in front, so new transactions are taken while
// the current one is worked on, and the output register lets results wait for
// the sink. After reset a clearing pass over both tables runs with in_ready
// low; configuration writes are taken at any time. Depends on urt_pkg,
// urt_front, urt_back and assert_macros.svh.
`include "assert_macros.svh"
module udp_pairing_rendezvous_table #(
  parameter int WAIT_DEPTH  = 1024,
  parameter int MATCH_DEPTH = 512,
  parameter int CODE_BYTES  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  urt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output urt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import urt_pkg::*;

  cfg_t cfg_r;
  logic clearing;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_to    <= RST_TIMEOUT;
      cfg_r.match_to   <= RST_TIMEOUT;
      cfg_r.salt       <= RST_SALT;
      cfg_r.local_addr <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WAIT_TO:  cfg_r.wait_to    <= cfg_wdata;
        CFG_MATCH_TO: cfg_r.match_to   <= cfg_wdata;
        CFG_SALT:     cfg_r.salt       <= cfg_wdata;
        CFG_LOCAL:    cfg_r.local_addr <= cfg_wdata;
        default:      cfg_r.wait_to    <= cfg_r.wait_to;
      endcase
    end
  end

  urt_front #(
    .CODE_BYTES (CODE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .hold     (clearing),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  urt_back #(
    .WAIT_DEPTH  (WAIT_DEPTH),
    .MATCH_DEPTH (MATCH_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .clearing  (clearing)
  );

  // Checks
  `URT_ASSERT(a_no_take_clear, clearing |-> !in_ready)
  `URT_ASSERT(a_pop_has_cmd, q_pop |-> q_valid)
  `URT_ASSERT(a_fwd_last, (out_valid && out_data.kind == KIND_FWD) |-> out_data.last)
  `URT_ASSERT_ANY(a_rst_blocks, !rst_n |=> !in_ready)

endmodule

// ===== design/urt_front.sv =====
// Front end: classifies input transactions and queues them for the back end.
// Depends on urt_pkg.
module urt_front #(
  parameter int CODE_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  urt_pkg::in_item_t  in_data,
  input  logic               hold,
  output logic               q_valid,
  output urt_pkg::cmd_t      q_cmd,
  input  logic               q_pop
);
  import urt_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  cmd_t           cmd;
  logic           hello_ok;
  logic           relay_ok;
  logic           push;
  cmd_t           q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;

  // Classify the transaction and mask the link code to its length
  always_comb begin
    hello_ok = in_data.nonce != 64'd0 && in_data.client_id != 64'd0 &&
               in_data.code_length != 8'd0 && in_data.code_length <= 8'(CODE_BYTES);
    relay_ok = in_data.session != 64'd0 && in_data.player_id <= 8'd1;
    cmd.now     = in_data.now_ms;
    cmd.nonce   = in_data.nonce;
    cmd.id      = in_data.client_id;
    cmd.session = in_data.session;
    cmd.pid     = in_data.player_id[0];
    cmd.len     = in_data.code_length[3:0];
    cmd.src     = {in_data.source_address, in_data.source_port};
    for (int b = 0; b < MAX_CODE; b++) begin
      cmd.code[8*b +: 8] = (in_data.code_length > 8'(b)) ? in_data.code_bytes[8*b +: 8] : 8'h00;
    end
    if (in_data.func == FUNC_HELLO && hello_ok) begin
      cmd.op = OP_HELLO;
    end else if (in_data.func == FUNC_RELAY && relay_ok) begin
      cmd.op = OP_RELAY;
    end else begin
      cmd.op = OP_TICK;
    end
  end

  assign in_ready = (cnt_r != (QAW+1)'(QDEPTH)) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != '0;
  assign q_cmd    = q_mem[rd_ptr_r];

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/urt_back.sv =====
// Back end: scans and ages both tables, applies the command, emits results.
// Depends on urt_pkg; holds the waiting and match table memories.
module urt_back #(
  parameter int WAIT_DEPTH  = 1024,
  parameter int MATCH_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  urt_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  urt_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output urt_pkg::out_item_t out_data,
  output logic               clearing
);
  import urt_pkg::*;

  localparam int WAW      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int MAW      = (MATCH_DEPTH > 1) ? $clog2(MATCH_DEPTH) : 1;
  localparam int SCAN_LEN = (WAIT_DEPTH > MATCH_DEPTH) ? WAIT_DEPTH : MATCH_DEPTH;
  localparam int CW       = $clog2(SCAN_LEN + 1);

  bk_state_t      state_r, state_nxt;
  logic [CW-1:0]  cnt_r;
  cmd_t           cmd_r;

  wait_rec_t      wmem [WAIT_DEPTH];
  match_rec_t     mmem [MATCH_DEPTH];
  logic           w_re, w_we, m_re, m_we;
  logic [WAW-1:0] w_waddr;
  logic [MAW-1:0] m_waddr;
  wait_rec_t      w_wdata, wrd_r;
  match_rec_t     m_wdata, mrd_r;
  logic           wok_r, mok_r;
  logic [WAW-1:0] widx_r;
  logic [MAW-1:0] midx_r;

  // Scan captures
  logic           wn_f_r, wn_same_r, wi_f_r, wp_f_r, wf_f_r;
  logic [WAW-1:0] wn_idx_r, wi_idx_r, wp_idx_r, wf_idx_r;
  wait_rec_t      wn_rec_r, wp_rec_r;
  logic           mh_f_r, mh_p_r, mi_f_r, mi_p_r, mf_f_r;
  logic [MAW-1:0] mh_idx_r, mi_idx_r, mf_idx_r;
  match_rec_t     mh_rec_r, mi_rec_r;

  // Result holding
  match_rec_t     res_rec_r;
  logic           res_kind_r, res_p_r;
  logic           out_vld_r;
  out_item_t      out_r;

  logic           w_nhit, w_ihit, w_part, w_stale;
  logic           m_hit, m_ihit, m_stale;
  logic [63:0]    w_age, m_age;
  logic           act_notice, act_fwd;
  match_rec_t     act_m;
  wait_rec_t      act_w;
  logic           load;
  out_item_t      item;
  logic [47:0]    adv0, adv1;

  assign clearing  = state_r == BK_CLEAR;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign load      = !out_vld_r || out_ready;

  // Per entry tests on the data read back during the scan
  always_comb begin
    w_age   = cmd_r.now - wrd_r.seen;
    m_age   = cmd_r.now - mrd_r.seen;
    w_nhit  = wrd_r.vld && wrd_r.nonce == cmd_r.nonce;
    w_ihit  = wrd_r.vld && wrd_r.id == cmd_r.id;
    w_part  = wrd_r.vld && wrd_r.nonce != cmd_r.nonce && wrd_r.id != cmd_r.id &&
              wrd_r.len == cmd_r.len && wrd_r.code == cmd_r.code;
    w_stale = wrd_r.vld && w_age >= {32'd0, cfg.wait_to};
    m_ihit  = mrd_r.vld && (mrd_r.id0 == cmd_r.id || mrd_r.id1 == cmd_r.id);
    m_stale = mrd_r.vld && m_age >= {32'd0, cfg.match_to};
    if (cmd_r.op == OP_RELAY) begin
      m_hit = mrd_r.vld && mrd_r.sess == cmd_r.session &&
              (cmd_r.pid ? (mrd_r.nonce1 == cmd_r.nonce && mrd_r.id1 == cmd_r.id)
                         : (mrd_r.nonce0 == cmd_r.nonce && mrd_r.id0 == cmd_r.id));
    end else begin
      m_hit = mrd_r.vld && (mrd_r.nonce0 == cmd_r.nonce || mrd_r.nonce1 == cmd_r.nonce);
    end
  end

  // Work out the table update for the current command
  always_comb begin
    act_notice = 1'b0;
    act_fwd    = 1'b0;
    act_m      = mh_rec_r;
    act_w      = wn_rec_r;
    if (cmd_r.op == OP_HELLO) begin
      if (mh_f_r) begin
        act_m.vld  = 1'b1;
        if (mh_p_r) act_m.addr1 = cmd_r.src;
        else        act_m.addr0 = cmd_r.src;
        act_m.seen = cmd_r.now;
        act_notice = 1'b1;
      end else if (mi_f_r) begin
        act_m     = mi_rec_r;
        act_m.vld = 1'b1;
        if (mi_p_r) begin
          act_m.nonce1 = cmd_r.nonce;
          act_m.addr1  = cmd_r.src;
        end else begin
          act_m.nonce0 = cmd_r.nonce;
          act_m.addr0  = cmd_r.src;
        end
        act_m.sess = new_session(act_m.nonce0, act_m.nonce1, cmd_r.now, cfg.salt);
        act_m.seen = cmd_r.now;
        act_notice = 1'b1;
      end else if (wn_f_r) begin
        act_w.vld  = 1'b1;
        act_w.src  = cmd_r.src;
        act_w.seen = cmd_r.now;
      end else if (wi_f_r || !wp_f_r) begin
        act_w = '{vld: 1'b1, nonce: cmd_r.nonce, id: cmd_r.id, code: cmd_r.code,
                  len: cmd_r.len, src: cmd_r.src, seen: cmd_r.now};
      end else if (mf_f_r) begin
        act_m.vld = 1'b1;
        if (wp_rec_r.id < cmd_r.id) begin
          act_m.nonce0 = wp_rec_r.nonce;
          act_m.id0    = wp_rec_r.id;
          act_m.addr0  = wp_rec_r.src;
          act_m.nonce1 = cmd_r.nonce;
          act_m.id1    = cmd_r.id;
          act_m.addr1  = cmd_r.src;
        end else begin
          act_m.nonce1 = wp_rec_r.nonce;
          act_m.id1    = wp_rec_r.id;
          act_m.addr1  = wp_rec_r.src;
          act_m.nonce0 = cmd_r.nonce;
          act_m.id0    = cmd_r.id;
          act_m.addr0  = cmd_r.src;
        end
        act_m.sess = new_session(act_m.nonce0, act_m.nonce1, cmd_r.now, cfg.salt);
        act_m.seen = cmd_r.now;
        act_notice = 1'b1;
      end
    end else if (cmd_r.op == OP_RELAY && mh_f_r) begin
      act_m.vld  = 1'b1;
      if (cmd_r.pid) act_m.addr1 = cmd_r.src;
      else           act_m.addr0 = cmd_r.src;
      act_m.seen = cmd_r.now;
      act_fwd    = 1'b1;
    end
  end

  // Build the result transaction from the held match record
  always_comb begin
    adv0 = advertise(res_rec_r.addr0, res_rec_r.addr1, cfg.local_addr);
    adv1 = advertise(res_rec_r.addr1, res_rec_r.addr0, cfg.local_addr);
    item = '0;
    if (res_kind_r) begin
      item.kind         = KIND_FWD;
      item.dest_address = res_p_r ? res_rec_r.addr0[47:16] : res_rec_r.addr1[47:16];
      item.dest_port    = res_p_r ? res_rec_r.addr0[15:0] : res_rec_r.addr1[15:0];
      item.last         = 1'b1;
    end else if (state_r == BK_OUT1) begin
      item.kind         = KIND_NOTICE;
      item.dest_address = res_rec_r.addr1[47:16];
      item.dest_port    = res_rec_r.addr1[15:0];
      item.slot         = 1'b1;
      item.slot_nonce   = res_rec_r.nonce1;
      item.session_out  = res_rec_r.sess;
      item.peer_address = adv0[47:16];
      item.peer_port    = adv0[15:0];
      item.last         = 1'b1;
    end else begin
      item.kind         = KIND_NOTICE;
      item.dest_address = res_rec_r.addr0[47:16];
      item.dest_port    = res_rec_r.addr0[15:0];
      item.slot         = 1'b0;
      item.slot_nonce   = res_rec_r.nonce0;
      item.session_out  = res_rec_r.sess;
      item.peer_address = adv1[47:16];
      item.peer_port    = adv1[15:0];
      item.last         = 1'b0;
    end
  end

  // Next state, memory ports and queue pop
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    w_re      = 1'b0;
    m_re      = 1'b0;
    w_we      = 1'b0;
    m_we      = 1'b0;
    w_waddr   = widx_r;
    m_waddr   = midx_r;
    w_wdata   = wrd_r;
    m_wdata   = mrd_r;
    case (state_r)
      BK_CLEAR: begin
        w_we    = cnt_r < CW'(WAIT_DEPTH);
        m_we    = cnt_r < CW'(MATCH_DEPTH);
        w_waddr = cnt_r[WAW-1:0];
        m_waddr = cnt_r[MAW-1:0];
        w_wdata = '0;
        m_wdata = '0;
        if (cnt_r == CW'(SCAN_LEN - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        w_re = cnt_r < CW'(SCAN_LEN) && cnt_r < CW'(WAIT_DEPTH);
        m_re = cnt_r < CW'(SCAN_LEN) && cnt_r < CW'(MATCH_DEPTH);
        // drop stale entries as they stream past
        if (wok_r && w_stale) begin
          w_we        = 1'b1;
          w_wdata.vld = 1'b0;
        end
        if (mok_r && m_stale) begin
          m_we        = 1'b1;
          m_wdata.vld = 1'b0;
        end
        if (cnt_r == CW'(SCAN_LEN) && !wok_r && !mok_r) state_nxt = BK_ACT;
      end
      BK_ACT: begin
        if (cmd_r.op == OP_HELLO) begin
          if (mh_f_r) begin
            m_we = 1'b1; m_waddr = mh_idx_r; m_wdata = act_m;
          end else if (mi_f_r) begin
            m_we = 1'b1; m_waddr = mi_idx_r; m_wdata = act_m;
          end else if (wn_f_r) begin
            w_we = wn_same_r; w_waddr = wn_idx_r; w_wdata = act_w;
          end else if (wi_f_r) begin
            w_we = 1'b1; w_waddr = wi_idx_r; w_wdata = act_w;
          end else if (!wp_f_r) begin
            w_we = wf_f_r; w_waddr = wf_idx_r; w_wdata = act_w;
          end else if (mf_f_r) begin
            m_we = 1'b1; m_waddr = mf_idx_r; m_wdata = act_m;
            w_we = 1'b1; w_waddr = wp_idx_r; w_wdata = '0;
          end
        end else if (act_fwd) begin
          m_we = 1'b1; m_waddr = mh_idx_r; m_wdata = act_m;
        end
        state_nxt = (act_notice || act_fwd) ? BK_OUT0 : BK_IDLE;
      end
      BK_OUT0: begin
        if (load) state_nxt = res_kind_r ? BK_IDLE : BK_OUT1;
      end
      BK_OUT1: begin
        if (load) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Waiting table memory
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
  end

  always_ff @(posedge clk) begin
    if (w_re) wrd_r <= wmem[cnt_r[WAW-1:0]];
  end

  // Match table memory
  always_ff @(posedge clk) begin
    if (m_we) mmem[m_waddr] <= m_wdata;
  end

  always_ff @(posedge clk) begin
    if (m_re) mrd_r <= mmem[cnt_r[MAW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_CLEAR;
      cnt_r     <= '0;
      wok_r     <= 1'b0;
      mok_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wok_r   <= w_re;
      mok_r   <= m_re;
      if (state_r == BK_CLEAR || (state_r == BK_SCAN && cnt_r < CW'(SCAN_LEN))) begin
        cnt_r <= (state_nxt == BK_IDLE) ? '0 : cnt_r + 1'b1;
      end else if (state_r == BK_IDLE) begin
        cnt_r <= '0;
      end
      if ((state_r == BK_OUT0 || state_r == BK_OUT1) && load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Capture command, first hits of the scan and the result record
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && q_valid) begin
      cmd_r  <= q_cmd;
      wn_f_r <= 1'b0;
      wi_f_r <= 1'b0;
      wp_f_r <= 1'b0;
      wf_f_r <= 1'b0;
      mh_f_r <= 1'b0;
      mi_f_r <= 1'b0;
      mf_f_r <= 1'b0;
    end
    if (state_r == BK_SCAN) begin
      widx_r <= cnt_r[WAW-1:0];
      midx_r <= cnt_r[MAW-1:0];
    end
    if (wok_r) begin
      if (!wn_f_r && w_nhit) begin
        wn_f_r    <= 1'b1;
        wn_idx_r  <= widx_r;
        wn_same_r <= wrd_r.id == cmd_r.id;
        wn_rec_r  <= wrd_r;
      end
      if (!wi_f_r && w_ihit) begin
        wi_f_r   <= 1'b1;
        wi_idx_r <= widx_r;
      end
      if (!wp_f_r && w_part) begin
        wp_f_r   <= 1'b1;
        wp_idx_r <= widx_r;
        wp_rec_r <= wrd_r;
      end
      if (!wf_f_r && !wrd_r.vld) begin
        wf_f_r   <= 1'b1;
        wf_idx_r <= widx_r;
      end
    end
    if (mok_r) begin
      if (!mh_f_r && m_hit) begin
        mh_f_r   <= 1'b1;
        mh_idx_r <= midx_r;
        mh_p_r   <= (cmd_r.op == OP_RELAY) ? cmd_r.pid : (mrd_r.nonce0 != cmd_r.nonce);
        mh_rec_r <= mrd_r;
      end
      if (!mi_f_r && m_ihit) begin
        mi_f_r   <= 1'b1;
        mi_idx_r <= midx_r;
        mi_p_r   <= mrd_r.id0 != cmd_r.id;
        mi_rec_r <= mrd_r;
      end
      if (!mf_f_r && !mrd_r.vld) begin
        mf_f_r   <= 1'b1;
        mf_idx_r <= midx_r;
      end
    end
    if (state_r == BK_ACT) begin
      res_rec_r  <= act_m;
      res_kind_r <= act_fwd;
      res_p_r    <= cmd_r.pid;
    end
    if ((state_r == BK_OUT0 || state_r == BK_OUT1) && load) begin
      out_r <= item;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the rendezvous pairing table: directed table, then random hellos,
// relays and ticks, all checked against a behavioural pairing predictor. Depends on urt_pkg and the DUT.
module testbench;
  import urt_pkg::*;

  localparam int WDEPTH = 1024;
  localparam int MDEPTH = 512;
  localparam int PASS_CYC = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  udp_pairing_rendezvous_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic [31:0] p_wait_to, p_match_to, p_salt, p_local;
  wait_rec_t  p_wait [WDEPTH];
  match_rec_t p_match [MDEPTH];
  logic [47:0] p_adv0 [MDEPTH];
  logic [47:0] p_adv1 [MDEPTH];

  out_item_t expected_notices [$];
  int errors = 0;
  int results_seen = 0;
  int pairings = 0;
  int forwards = 0;
  bit stall_long = 1'b0;
  bit quiet_idle = 1'b0;

  // Pool of players for well-formed sequences
  logic [63:0] pl_nonce [8];
  logic [63:0] pl_id [8];
  logic [63:0] pl_code [8];
  logic [47:0] pl_src [8];
  logic [63:0] now_clock = 64'd1000;

  function automatic logic loop_net(input logic [31:0] a);
    return a[31:24] == 8'd127;
  endfunction

  function automatic logic [63:0] mix_session(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] t);
    logic [63:0] v;
    v = a ^ (b << 1) ^ t ^ {p_salt, 32'd0};
    v ^= v << 13;
    v ^= v >> 7;
    v ^= v << 17;
    return (v == 64'd0) ? 64'd1 : v;
  endfunction

  function automatic logic [47:0] adv_one(input logic [47:0] mine, input logic [47:0] other);
    if (loop_net(mine[47:16]) && !loop_net(other[47:16]) && p_local != 32'd0 &&
        !loop_net(p_local))
      return {p_local, mine[15:0]};
    return mine;
  endfunction

  task automatic refresh_adv(input int i);
    p_adv0[i] = adv_one(p_match[i].addr0, p_match[i].addr1);
    p_adv1[i] = adv_one(p_match[i].addr1, p_match[i].addr0);
  endtask

  task automatic push_notices(input int i);
    out_item_t o;
    o = '0;
    o.kind = KIND_NOTICE;
    o.dest_address = p_match[i].addr0[47:16];
    o.dest_port = p_match[i].addr0[15:0];
    o.slot = 1'b0;
    o.slot_nonce = p_match[i].nonce0;
    o.session_out = p_match[i].sess;
    o.peer_address = p_adv1[i][47:16];
    o.peer_port = p_adv1[i][15:0];
    o.last = 1'b0;
    expected_notices.push_back(o);
    o.dest_address = p_match[i].addr1[47:16];
    o.dest_port = p_match[i].addr1[15:0];
    o.slot = 1'b1;
    o.slot_nonce = p_match[i].nonce1;
    o.peer_address = p_adv0[i][47:16];
    o.peer_port = p_adv0[i][15:0];
    o.last = 1'b1;
    expected_notices.push_back(o);
  endtask

  // Hello handling: refresh match, rekey match, refresh waiting, rekey waiting, join or pair
  task automatic pair_hello(input in_item_t it);
    logic [47:0] src;
    logic [63:0] code;
    logic [63:0] mask;
    int len, partner, q;
    src = {it.source_address, it.source_port};
    len = it.code_length;
    partner = -1;
    if (it.nonce == 0 || it.client_id == 0 || len == 0 || len > 8) return;
    mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 1);
    code = it.code_bytes & mask;
    for (int i = 0; i < MDEPTH; i++) begin
      if (!p_match[i].vld) continue;
      if (p_match[i].nonce0 == it.nonce) p_match[i].addr0 = src;
      else if (p_match[i].nonce1 == it.nonce) p_match[i].addr1 = src;
      else continue;
      refresh_adv(i);
      p_match[i].seen = it.now_ms;
      push_notices(i);
      return;
    end
    for (int i = 0; i < MDEPTH; i++) begin
      if (!p_match[i].vld) continue;
      if (p_match[i].id0 == it.client_id) begin
        p_match[i].nonce0 = it.nonce;
        p_match[i].addr0 = src;
      end else if (p_match[i].id1 == it.client_id) begin
        p_match[i].nonce1 = it.nonce;
        p_match[i].addr1 = src;
      end else continue;
      p_match[i].sess = mix_session(p_match[i].nonce0, p_match[i].nonce1, it.now_ms);
      p_match[i].seen = it.now_ms;
      refresh_adv(i);
      push_notices(i);
      return;
    end
    for (int i = 0; i < WDEPTH; i++) begin
      if (!p_wait[i].vld || p_wait[i].nonce != it.nonce) continue;
      if (p_wait[i].id != it.client_id) return;
      p_wait[i].src = src;
      p_wait[i].seen = it.now_ms;
      return;
    end
    for (int i = 0; i < WDEPTH; i++) begin
      if (!p_wait[i].vld || p_wait[i].id != it.client_id) continue;
      p_wait[i].nonce = it.nonce;
      p_wait[i].src = src;
      p_wait[i].len = 4'(len);
      p_wait[i].code = code;
      p_wait[i].seen = it.now_ms;
      return;
    end
    for (int i = 0; i < WDEPTH && partner < 0; i++)
      if (p_wait[i].vld && p_wait[i].nonce != it.nonce && p_wait[i].id != it.client_id &&
          p_wait[i].len == len && p_wait[i].code == code)
        partner = i;
    if (partner < 0) begin
      for (int i = 0; i < WDEPTH; i++) begin
        if (p_wait[i].vld) continue;
        p_wait[i] = '{vld: 1'b1, nonce: it.nonce, id: it.client_id, code: code,
                      len: 4'(len), src: src, seen: it.now_ms};
        return;
      end
      return;
    end
    for (int i = 0; i < MDEPTH; i++) begin
      if (p_match[i].vld) continue;
      q = (p_wait[partner].id < it.client_id ||
           (p_wait[partner].id == it.client_id && p_wait[partner].nonce < it.nonce)) ? 0 : 1;
      p_match[i] = '0;
      p_match[i].vld = 1'b1;
      if (q == 0) begin
        p_match[i].nonce0 = p_wait[partner].nonce;
        p_match[i].id0 = p_wait[partner].id;
        p_match[i].addr0 = p_wait[partner].src;
        p_match[i].nonce1 = it.nonce;
        p_match[i].id1 = it.client_id;
        p_match[i].addr1 = src;
      end else begin
        p_match[i].nonce1 = p_wait[partner].nonce;
        p_match[i].id1 = p_wait[partner].id;
        p_match[i].addr1 = p_wait[partner].src;
        p_match[i].nonce0 = it.nonce;
        p_match[i].id0 = it.client_id;
        p_match[i].addr0 = src;
      end
      p_match[i].sess = mix_session(p_match[i].nonce0, p_match[i].nonce1, it.now_ms);
      p_match[i].seen = it.now_ms;
      p_wait[partner].vld = 1'b0;
      refresh_adv(i);
      push_notices(i);
      pairings++;
      return;
    end
  endtask

  // Relay handling: one forward to the other slot of a fitting match
  task automatic forward_relay(input in_item_t it);
    out_item_t o;
    logic [47:0] src;
    src = {it.source_address, it.source_port};
    if (it.session == 0 || it.player_id > 8'd1) return;
    for (int i = 0; i < MDEPTH; i++) begin
      if (!p_match[i].vld || p_match[i].sess != it.session) continue;
      if (it.player_id == 8'd0) begin
        if (p_match[i].nonce0 != it.nonce || p_match[i].id0 != it.client_id) continue;
        p_match[i].addr0 = src;
      end else begin
        if (p_match[i].nonce1 != it.nonce || p_match[i].id1 != it.client_id) continue;
        p_match[i].addr1 = src;
      end
      p_match[i].seen = it.now_ms;
      o = '0;
      o.kind = KIND_FWD;
      {o.dest_address, o.dest_port} = (it.player_id == 8'd0) ? p_match[i].addr1 :
                                                               p_match[i].addr0;
      o.last = 1'b1;
      expected_notices.push_back(o);
      forwards++;
      return;
    end
  endtask

  task automatic predict_item(input in_item_t it);
    if (it.func == FUNC_HELLO) pair_hello(it);
    else if (it.func == FUNC_RELAY) forward_relay(it);
    for (int i = 0; i < WDEPTH; i++)
      if (p_wait[i].vld && (it.now_ms - p_wait[i].seen) >= {32'd0, p_wait_to})
        p_wait[i].vld = 1'b0;
    for (int i = 0; i < MDEPTH; i++)
      if (p_match[i].vld && (it.now_ms - p_match[i].seen) >= {32'd0, p_match_to})
        p_match[i].vld = 1'b0;
  endtask

  // Send one transaction, holding valid and payload until accepted; valid stays
  // high so the next transaction can follow at once
  task automatic send_item(input in_item_t it, input bit may_idle);
    if (may_idle && !quiet_idle)
      while ($urandom_range(99) < 16) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WAIT_TO:  p_wait_to = val;
      CFG_MATCH_TO: p_match_to = val;
      CFG_SALT:     p_salt = val;
      default:      p_local = val;
    endcase
    @(negedge clk);
  endtask

  // Drop valid, wait until all results are in, then let the current pass finish
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_notices.size() != 0) @(negedge clk);
    repeat (3 * PASS_CYC) @(negedge clk);
  endtask

  function automatic in_item_t mk(input logic [1:0] f, input logic [63:0] t,
                                  input logic [63:0] n, input logic [63:0] id,
                                  input logic [63:0] s, input logic [7:0] pid,
                                  input logic [7:0] len, input logic [63:0] code,
                                  input logic [47:0] src);
    in_item_t it;
    it.func = f; it.now_ms = t; it.nonce = n; it.client_id = id; it.session = s;
    it.player_id = pid; it.code_length = len; it.code_bytes = code;
    {it.source_address, it.source_port} = src;
    return it;
  endfunction

  // Directed rows: stimulus, plus fields for a hand-typed result that no row sets
  typedef struct {
    in_item_t stim;
    bit       typed;
    out_item_t want;
  } row_t;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Current session of the match holding a client id, or zero
  function automatic logic [63:0] session_of(input logic [63:0] id, output bit slot1,
                                             output logic [63:0] n);
    for (int i = 0; i < MDEPTH; i++) begin
      if (!p_match[i].vld) continue;
      if (p_match[i].id0 == id) begin slot1 = 0; n = p_match[i].nonce0; return p_match[i].sess; end
      if (p_match[i].id1 == id) begin slot1 = 1; n = p_match[i].nonce1; return p_match[i].sess; end
    end
    slot1 = 0; n = 0;
    return 64'd0;
  endfunction

  task automatic random_item();
    in_item_t it;
    int k, r;
    bit s1;
    logic [63:0] sn, sess;
    k = $urandom_range(7);
    r = $urandom_range(99);
    now_clock += $urandom_range(400);
    it = mk(2'd2, now_clock, pl_nonce[k], pl_id[k], 0, 0, 8'd4, pl_code[k], pl_src[k]);
    if ($urandom_range(3) == 0) {it.source_address, it.source_port} = {$urandom, 16'($urandom)};
    if (r < 45) begin
      it.func = FUNC_HELLO;
      if ($urandom_range(9) == 0) it.nonce = rnd64();
      if ($urandom_range(19) == 0) pl_nonce[k] = it.nonce;
    end else if (r < 80) begin
      sess = session_of(pl_id[k], s1, sn);
      it.func = FUNC_RELAY;
      it.session = sess;
      it.player_id = {7'd0, s1};
      it.nonce = sn;
      if ($urandom_range(7) == 0) it.player_id = 8'($urandom);
      if ($urandom_range(7) == 0) it.session = rnd64();
    end else if (r < 92) begin
      it = mk(2'($urandom), now_clock, rnd64(), rnd64(), rnd64(), 8'($urandom),
              8'($urandom_range(10)), rnd64(), {$urandom, 16'($urandom)});
      if ($urandom_range(3) == 0) it.code_length = 8'($urandom);
    end else begin
      it.func = 2'($urandom_range(2, 3));
      if ($urandom_range(3) == 0) now_clock += $urandom_range(40000);
      it.now_ms = now_clock;
    end
    send_item(it, 1'b1);
  endtask

  row_t rows [$];

  // Stimulus
  initial begin
    row_t r;
    p_wait_to = 32'd30000; p_match_to = 32'd30000; p_salt = 32'd1; p_local = 32'd0;
    foreach (p_wait[i]) p_wait[i] = '0;
    foreach (p_match[i]) p_match[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    r.typed = 0; r.want = '0;
    r.stim = mk(2'd2, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 10, 0, 5, 0, 0, 1, 8'h41, {32'h0a000001, 16'd1}); rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 11, 5, 0, 0, 0, 1, 8'h41, {32'h0a000001, 16'd1}); rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 12, 5, 5, 0, 0, 0, 8'h41, {32'h0a000001, 16'd1}); rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 13, 5, 5, 0, 0, 9, 8'h41, {32'h0a000001, 16'd1}); rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 14, 5, 5, 0, 0, 255, '1, '1); rows.push_back(r);
    // Pair a loopback player with a remote one
    r.stim = mk(FUNC_HELLO, 20, 64'h11, 64'h200, 0, 0, 2, 64'hFFFF_0000_0000_4142,
                {32'h7f000001, 16'd5000});
    rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 21, 64'h11, 64'h999, 0, 0, 2, 64'h4142, {32'hc0a80001, 16'd9});
    rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 22, 64'h22, 64'h100, 0, 0, 2, 64'h4142, {32'hc0a80002, 16'hffff});
    rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 23, 64'h22, 64'h100, 0, 0, 2, 64'h4142, {32'hc0a80003, 16'd7});
    rows.push_back(r);
    r.stim = mk(FUNC_HELLO, 24, 64'h33, 64'h200, 0, 0, 2, 64'h4142, {32'h7f000002, 16'd8});
    rows.push_back(r);
    r.stim = mk(FUNC_RELAY, 25, 64'h11, 64'h200, 0, 8'd1, 0, 0, 0); rows.push_back(r);
    r.stim = mk(FUNC_RELAY, 26, 64'h11, 64'h200, 64'h1, 8'd2, 0, 0, 0); rows.push_back(r);
    r.stim = mk(FUNC_RELAY, 27, '1, '1, '1, 8'hff, 8'hff, '1, '1); rows.push_back(r);
    r.stim = mk(2'd3, '1, '1, '1, '1, 8'hff, 8'hff, '1, '1); rows.push_back(r);
    r.stim = mk(FUNC_HELLO, '1, '1, '1, '1, 8'hff, 8'd8, '1, '1); rows.push_back(r);
    foreach (rows[i]) begin
      send_item(rows[i].stim, 1'b0);
    end
    drain();

    // Exercise the loopback substitution and the register extremes
    write_reg(CFG_LOCAL, 32'h0a0b0c0d);
    write_reg(CFG_SALT, 32'hffffffff);
    write_reg(CFG_WAIT_TO, 32'hffffffff);
    write_reg(CFG_MATCH_TO, 32'hffffffff);
    for (int k = 0; k < 8; k++) begin
      pl_nonce[k] = rnd64() | 64'd1;
      pl_id[k] = {$urandom, 28'($urandom), 4'(k + 1)};
      pl_code[k] = 64'(32'h5a5a0000 | (k >> 1));
      pl_src[k] = {(k % 3 == 0) ? 8'd127 : 8'($urandom_range(1, 126)), 24'($urandom),
                   16'($urandom)};
    end
    for (int n = 0; n < 90; n++) random_item();

    // Long receiver hold-off while the sender keeps going
    stall_long = 1'b1;
    quiet_idle = 1'b1;
    for (int n = 0; n < 30; n++) random_item();
    quiet_idle = 1'b0;
    drain();

    write_reg(CFG_LOCAL, 32'h7f000009);
    write_reg(CFG_SALT, 32'd0);
    write_reg(CFG_WAIT_TO, 32'd1500);
    write_reg(CFG_MATCH_TO, 32'd2500);
    for (int n = 0; n < 80; n++) random_item();
    drain();

    write_reg(CFG_LOCAL, 32'hffffffff);
    write_reg(CFG_WAIT_TO, 32'd1);
    write_reg(CFG_MATCH_TO, 32'd1);
    for (int n = 0; n < 15; n++) random_item();
    drain();

    write_reg(CFG_LOCAL, 32'd0);
    write_reg(CFG_WAIT_TO, 32'd30000);
    write_reg(CFG_MATCH_TO, 32'd30000);
    write_reg(CFG_SALT, 32'h1234_5678);
    for (int n = 0; n < 60; n++) random_item();
    drain();

    $display("Covered %0d pairings and %0d relay forwards over %0d results.",
             pairings, forwards, results_seen);
    if (errors == 0 && expected_notices.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Receiver ready: random idling, one long hold-off counted here
  initial begin
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (stall_long && held < 3000) begin
        held++;
        out_ready <= 1'b0;
      end else if (quiet_idle) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 16);
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_notices.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR unexpected result %p", out_data);
      end else begin
        want = expected_notices.pop_front();
        if (want.kind !== out_data.kind || want.dest_address !== out_data.dest_address ||
            want.dest_port !== out_data.dest_port || want.slot !== out_data.slot ||
            want.slot_nonce !== out_data.slot_nonce ||
            want.session_out !== out_data.session_out ||
            want.peer_address !== out_data.peer_address ||
            want.peer_port !== out_data.peer_port || want.last !== out_data.last) begin
          errors++;
          if (errors <= 10) $display("ERROR result mismatch: expected %p actual %p",
                                     want, out_data);
        end
      end
    end
  end

  // Give up after a generous fixed time
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
